FILE: src/rpn_pkg.sv
// rpn_pkg: shared types and constants for the rpn stack calculator
// opcodes, status codes, controller states and controller/datapath command structs
// no dependencies
package rpn_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_SWAP  = 4'd5,
		OP_NEG   = 4'd6,
		OP_DUP   = 4'd7,
		OP_PEEK  = 4'd8,
		OP_CLEAR = 4'd9,
		OP_DUMP  = 4'd10
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNDER   = 3'd1,
		ST_DIVZERO = 3'd2,
		ST_BADOP   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECODE = 10'b00_0000_0010,
		S_GOT_T  = 10'b00_0000_0100,
		S_GOT_S  = 10'b00_0000_1000,
		S_EXEC   = 10'b00_0001_0000,
		S_WR2    = 10'b00_0010_0000,
		S_MULWR  = 10'b00_0100_0000,
		S_DIVW   = 10'b00_1000_0000,
		S_RESULT = 10'b01_0000_0000,
		S_DUMP   = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		RD_TOP      = 2'd0,
		RD_SECOND   = 2'd1,
		RD_PTR_NEXT = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		WA_COUNT  = 2'd0,
		WA_TOP    = 2'd1,
		WA_SECOND = 2'd2
	} wa_sel_t;

	typedef enum logic [2:0] {
		WD_OPERAND = 3'd0,
		WD_RDATA   = 3'd1,
		WD_NEG     = 3'd2,
		WD_S       = 3'd3,
		WD_T       = 3'd4,
		WD_ALU     = 3'd5,
		WD_PROD    = 3'd6,
		WD_QUO     = 3'd7
	} wd_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2,
		CNT_CLR  = 2'd3
	} cnt_op_t;

	typedef enum logic [1:0] {
		EMIT_NONE = 2'd0,
		EMIT_RES  = 2'd1,
		EMIT_DUMP = 2'd2
	} emit_t;

	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		logic    wr_en;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		cnt_op_t cnt_op;
		logic    cap_t;
		logic    cap_s;
		logic    alu_sub;
		logic    mul_en;
		logic    div_start;
		logic    res_load;
		logic    res_peek;
		status_t res_status;
		logic    ptr_init;
		logic    ptr_dec;
		emit_t   emit;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_ge2;
		logic cnt_full;
		logic t_zero;
		logic div_done;
		logic ptr_zero;
	} sts_t;

endpackage

FILE: src/rpn_stack_calculator.sv
// rpn_stack_calculator: top level of the reverse polish stack calculator
// joins rpn_ctrl and rpn_dp; depends on rpn_pkg
//
//  channel   handshake        payload
//  input     start / busy     operation, operand
//  result    strobe           value, has_value, status, last
//
// busy is high from the accepted item until its last result; one item at a time
// push, clear, bad opcode: result straight from decode; neg, dup, peek: after one stack read
// add, sub, swap, mul: after two stack reads and the write steps; div: waits on the one-bit-a-cycle divider
// dump: one result per cycle, one per stack entry, paced by the memory read port
// reset clears the stack count; the receiver cannot stall, results are never held
module rpn_stack_calculator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [3:0]               operation,
	input  logic signed [DATA_W-1:0] operand,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] value,
	output logic                     has_value,
	output logic [2:0]               status,
	output logic                     last
);

	cmd_t cmd;
	sts_t sts;

	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.strobe    (strobe)
	);

	rpn_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operand   (operand),
		.sts       (sts),
		.value     (value),
		.has_value (has_value),
		.status    (status),
		.last      (last)
	);

endmodule

FILE: src/rpn_div.sv
// rpn_div: iterative signed divider, one quotient bit per cycle, truncating
// depends on rpn_pkg
module rpn_div import rpn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic              done_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DATA_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			quo_q <= dividend[DATA_W-1] ? -dividend : dividend;
			den_q <= divisor[DATA_W-1] ? -divisor : divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			// restoring step: keep the difference when it did not borrow
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -quo_q : quo_q;

endmodule

FILE: src/rpn_dp.sv
// rpn_dp: datapath of the rpn calculator: stack memory, count, operand registers,
// adder, multiplier, divider and result registers; depends on rpn_pkg and rpn_div
module rpn_dp import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic signed [DATA_W-1:0] operand,
	output sts_t                     sts,
	output logic signed [DATA_W-1:0] value,
	output logic                     has_value,
	output logic [2:0]               status,
	output logic                     last
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [DATA_W-1:0] stack_mem_q [STACK_DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     ptr_q;
	logic [DATA_W-1:0] operand_q;
	logic [DATA_W-1:0] t_q;
	logic [DATA_W-1:0] s_q;
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] res_value_q;
	logic              res_has_q;
	status_t           res_status_q;

	logic [AW-1:0]     top_idx;
	logic [AW-1:0]     second_idx;
	logic [AW-1:0]     count_idx;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] alu;
	logic [DATA_W-1:0] quotient;
	logic              div_done;

	assign top_idx    = AW'(count_q - CW'(1));
	assign second_idx = AW'(count_q - CW'(2));
	assign count_idx  = AW'(count_q);
	assign alu        = cmd.alu_sub ? (s_q - t_q) : (s_q + t_q);

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (s_q),
		.divisor  (t_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_TOP:      raddr = top_idx;
			RD_SECOND:   raddr = second_idx;
			RD_PTR_NEXT: raddr = ptr_q - AW'(1);
			default:     raddr = top_idx;
		endcase
	end

	always_comb begin
		unique case (cmd.wa_sel)
			WA_COUNT:  waddr = count_idx;
			WA_TOP:    waddr = top_idx;
			WA_SECOND: waddr = second_idx;
			default:   waddr = top_idx;
		endcase
	end

	always_comb begin
		unique case (cmd.wd_sel)
			WD_OPERAND: wdata = operand_q;
			WD_RDATA:   wdata = rdata_q;
			WD_NEG:     wdata = -rdata_q;
			WD_S:       wdata = s_q;
			WD_T:       wdata = t_q;
			WD_ALU:     wdata = alu;
			WD_PROD:    wdata = prod_q;
			WD_QUO:     wdata = quotient;
			default:    wdata = alu;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			stack_mem_q[waddr] <= wdata;
		end
		rdata_q <= stack_mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_INC:  count_q <= count_q + CW'(1);
				CNT_DEC:  count_q <= count_q - CW'(1);
				CNT_CLR:  count_q <= '0;
				default:  count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			operand_q <= operand;
		end
		if (cmd.cap_t) begin
			t_q <= rdata_q;
		end
		if (cmd.cap_s) begin
			s_q <= rdata_q;
		end
		if (cmd.mul_en) begin
			prod_q <= s_q * t_q;
		end
		if (cmd.ptr_init) begin
			ptr_q <= top_idx;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - AW'(1);
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_has_q    <= cmd.res_peek;
			res_value_q  <= cmd.res_peek ? rdata_q : '0;
		end
	end

	assign sts.cnt_zero = (count_q == '0);
	assign sts.cnt_ge2  = (count_q >= CW'(2));
	assign sts.cnt_full = (count_q >= CW'(STACK_DEPTH));
	assign sts.t_zero   = (t_q == '0);
	assign sts.div_done = div_done;
	assign sts.ptr_zero = (ptr_q == '0);

	always_comb begin
		unique case (cmd.emit)
			EMIT_RES: begin
				value     = res_value_q;
				has_value = res_has_q;
				status    = res_status_q;
				last      = 1'b1;
			end
			EMIT_DUMP: begin
				value     = rdata_q;
				has_value = 1'b1;
				status    = ST_OK;
				last      = (ptr_q == '0);
			end
			default: begin
				value     = '0;
				has_value = 1'b0;
				status    = ST_OK;
				last      = 1'b0;
			end
		endcase
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wa_sel == WA_COUNT) |-> !sts.cnt_full)
		else $error("write above top of a full stack");
	a_pop_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_op == CNT_DEC) |-> sts.cnt_ge2)
		else $error("pop with fewer than two entries");
`endif

endmodule

FILE: src/rpn_ctrl.sv
// rpn_ctrl: controller state machine of the rpn calculator
// sequences stack reads, writes and results; depends on rpn_pkg
module rpn_ctrl import rpn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [3:0] operation,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy,
	output logic       strobe
);

	state_t state_q;
	state_t state_d;
	op_t    op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= op_t'(operation);
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d        = S_RESULT;
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_OK;
				unique case (op_q)
					OP_PUSH: begin
						if (sts.cnt_full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wa_sel = WA_COUNT;
							cmd.wd_sel = WD_OPERAND;
							cmd.cnt_op = CNT_INC;
						end
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
						if (!sts.cnt_ge2) begin
							cmd.res_status = ST_UNDER;
						end else begin
							cmd.res_load = 1'b0;
							cmd.rd_sel   = RD_TOP;
							state_d      = S_GOT_T;
						end
					end
					OP_NEG, OP_PEEK: begin
						if (sts.cnt_zero) begin
							cmd.res_status = ST_UNDER;
						end else begin
							cmd.res_load = 1'b0;
							cmd.rd_sel   = RD_TOP;
							state_d      = S_GOT_T;
						end
					end
					OP_DUP: begin
						if (sts.cnt_zero) begin
							cmd.res_status = ST_UNDER;
						end else if (sts.cnt_full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.res_load = 1'b0;
							cmd.rd_sel   = RD_TOP;
							state_d      = S_GOT_T;
						end
					end
					OP_CLEAR: begin
						cmd.cnt_op = CNT_CLR;
					end
					OP_DUMP: begin
						// an empty stack gives a single empty ok result
						if (!sts.cnt_zero) begin
							cmd.res_load = 1'b0;
							cmd.rd_sel   = RD_TOP;
							cmd.ptr_init = 1'b1;
							state_d      = S_DUMP;
						end
					end
					default: begin
						cmd.res_status = ST_BADOP;
					end
				endcase
			end
			S_GOT_T: begin
				cmd.cap_t = 1'b1;
				unique case (op_q)
					OP_NEG: begin
						cmd.wr_en    = 1'b1;
						cmd.wa_sel   = WA_TOP;
						cmd.wd_sel   = WD_NEG;
						cmd.res_load = 1'b1;
						state_d      = S_RESULT;
					end
					OP_DUP: begin
						cmd.wr_en    = 1'b1;
						cmd.wa_sel   = WA_COUNT;
						cmd.wd_sel   = WD_RDATA;
						cmd.cnt_op   = CNT_INC;
						cmd.res_load = 1'b1;
						state_d      = S_RESULT;
					end
					OP_PEEK: begin
						cmd.res_load = 1'b1;
						cmd.res_peek = 1'b1;
						state_d      = S_RESULT;
					end
					default: begin
						cmd.rd_sel = RD_SECOND;
						state_d    = S_GOT_S;
					end
				endcase
			end
			S_GOT_S: begin
				cmd.cap_s = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				unique case (op_q)
					OP_SWAP: begin
						cmd.wr_en  = 1'b1;
						cmd.wa_sel = WA_TOP;
						cmd.wd_sel = WD_S;
						state_d    = S_WR2;
					end
					OP_MUL: begin
						cmd.mul_en = 1'b1;
						state_d    = S_MULWR;
					end
					OP_DIV: begin
						if (sts.t_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_DIVZERO;
							state_d        = S_RESULT;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIVW;
						end
					end
					default: begin
						cmd.wr_en    = 1'b1;
						cmd.wa_sel   = WA_SECOND;
						cmd.wd_sel   = WD_ALU;
						cmd.alu_sub  = (op_q == OP_SUB);
						cmd.cnt_op   = CNT_DEC;
						cmd.res_load = 1'b1;
						state_d      = S_RESULT;
					end
				endcase
			end
			S_WR2: begin
				cmd.wr_en    = 1'b1;
				cmd.wa_sel   = WA_SECOND;
				cmd.wd_sel   = WD_T;
				cmd.res_load = 1'b1;
				state_d      = S_RESULT;
			end
			S_MULWR: begin
				cmd.wr_en    = 1'b1;
				cmd.wa_sel   = WA_SECOND;
				cmd.wd_sel   = WD_PROD;
				cmd.cnt_op   = CNT_DEC;
				cmd.res_load = 1'b1;
				state_d      = S_RESULT;
			end
			S_DIVW: begin
				if (sts.div_done) begin
					cmd.wr_en    = 1'b1;
					cmd.wa_sel   = WA_SECOND;
					cmd.wd_sel   = WD_QUO;
					cmd.cnt_op   = CNT_DEC;
					cmd.res_load = 1'b1;
					state_d      = S_RESULT;
				end
			end
			S_RESULT: begin
				cmd.emit = EMIT_RES;
				state_d  = S_IDLE;
			end
			S_DUMP: begin
				// show one entry a cycle while the next one down is read
				cmd.emit    = EMIT_DUMP;
				cmd.rd_sel  = RD_PTR_NEXT;
				cmd.ptr_dec = 1'b1;
				if (sts.ptr_zero) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = (cmd.emit != EMIT_NONE);

`ifndef SYNTH
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_DECODE))
		else $error("accepted item not decoded");
	a_result_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EMIT_RES) |=> (state_q == S_IDLE))
		else $error("status result did not end the item");
	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EMIT_DUMP && sts.ptr_zero) |=> (state_q == S_IDLE))
		else $error("dump ran past the bottom entry");
`endif

endmodule
